FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the palette quantizer.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is applied.
`define NPQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Concurrent check that also holds while reset is applied.
`define NPQ_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/npq_pkg.sv
// Constants, types and the distance function of the palette quantizer.
// No dependencies; used by nearest_palette_color_quantizer.
`default_nettype none

package npq_pkg;

	localparam int unsigned PAL_ENTRIES = 16;
	localparam int unsigned IDX_W       = 4;
	localparam int unsigned CHAN_W      = 8;
	// 16*255 + 4*255 + 8*255 = 7140 fits in 13 bits
	localparam int unsigned DIST_W      = 13;
	localparam int unsigned IN_DATA_W   = 24;
	localparam int unsigned OUT_DATA_W  = 8;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [IDX_W-1:0]  pal_idx_t;

	typedef struct packed {
		chan_t blue;
		chan_t green;
		chan_t red;
	} rgb_t;

	// Fixed 16-colour palette
	localparam chan_t PAL_RED [PAL_ENTRIES] = '{
		8'd0,   8'd0,   8'd0,   8'd0,   8'd170, 8'd170, 8'd170, 8'd170,
		8'd85,  8'd85,  8'd85,  8'd85,  8'd255, 8'd255, 8'd255, 8'd255
	};
	localparam chan_t PAL_GREEN [PAL_ENTRIES] = '{
		8'd0,   8'd0,   8'd170, 8'd170, 8'd0,   8'd0,   8'd85,  8'd170,
		8'd85,  8'd85,  8'd255, 8'd255, 8'd85,  8'd85,  8'd255, 8'd255
	};
	localparam chan_t PAL_BLUE [PAL_ENTRIES] = '{
		8'd0,   8'd170, 8'd0,   8'd170, 8'd0,   8'd170, 8'd170, 8'd170,
		8'd85,  8'd255, 8'd85,  8'd255, 8'd85,  8'd255, 8'd85,  8'd255
	};

	function automatic chan_t abs_diff(input chan_t a, input chan_t b);
		abs_diff = (a >= b) ? (a - b) : (b - a);
	endfunction

	// Weighted L1 distance: red x16, green x4, blue x8 as shifts
	function automatic dist_t pal_dist(input rgb_t px, input chan_t pr, input chan_t pg,
			input chan_t pb);
		chan_t dr;
		chan_t dg;
		chan_t db;
		dr = abs_diff(px.red, pr);
		dg = abs_diff(px.green, pg);
		db = abs_diff(px.blue, pb);
		pal_dist = DIST_W'({dr, 4'b0000}) + DIST_W'({dg, 2'b00}) + DIST_W'({db, 3'b000});
	endfunction

endpackage

`default_nettype wire

FILE: src/nearest_palette_color_quantizer.sv
// Nearest palette colour quantizer: RGB item in, 4-bit palette index out.
// Depends on npq_pkg and assert_macros.svh.
//
// Usage
// - Input stream s_axis: one 24-bit colour per item, red in bits 7:0,
//   green in 15:8, blue in 23:16.
// - Output stream m_axis: one result per input item, palette index in
//   bits 3:0 of tdata, bits 7:4 are zero.
// - The index is that of the palette entry with the smallest weighted
//   L1 distance (red x16, green x4, blue x8); ties go to the lowest index.
// - Registers: an accepted item is held in the input register, and its
//   result is offered from the result register.
// - Throughput: one item per cycle while m_axis_tready is high; the sixteen
//   distances and a four-level minimum tree sit between the two registers.
// - Stall: when m_axis_tready is low the result register holds, the input
//   register holds behind it, and s_axis_tready drops only once both are
//   full.
// - Reset: arst_n clears both valid flags; no items are in flight after it.
`default_nettype none

`include "assert_macros.svh"

module nearest_palette_color_quantizer (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// red [7:0], green [15:8], blue [23:16]
	input  wire logic [npq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// palette_index [3:0], zero fill [7:4]
	output logic [npq_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);

	logic              valid_s1;
	npq_pkg::rgb_t     pixel_s1;
	logic              valid_s2;
	npq_pkg::pal_idx_t index_s2;
	logic              adv_s2;
	logic              adv_s1;

	npq_pkg::dist_t    dist_l0 [16];
	npq_pkg::pal_idx_t idx_l0  [16];
	npq_pkg::dist_t    dist_l1 [8];
	npq_pkg::pal_idx_t idx_l1  [8];
	npq_pkg::dist_t    dist_l2 [4];
	npq_pkg::pal_idx_t idx_l2  [4];
	npq_pkg::dist_t    dist_l3 [2];
	npq_pkg::pal_idx_t idx_l3  [2];
	npq_pkg::pal_idx_t best_idx;

	// Advance each stage when the stage after it is empty or being emptied
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload registers, loaded on advance
	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			pixel_s1 <= npq_pkg::rgb_t'(s_axis_tdata);
		end
		if (adv_s2 && valid_s1) begin
			index_s2 <= best_idx;
		end
	end

	// Distance to every palette entry
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			dist_l0[i] = npq_pkg::pal_dist(pixel_s1, npq_pkg::PAL_RED[i],
				npq_pkg::PAL_GREEN[i], npq_pkg::PAL_BLUE[i]);
			idx_l0[i]  = npq_pkg::pal_idx_t'(i);
		end
	end

	// Minimum tree; the right side wins only when strictly nearer,
	// so the lower index is kept on a tie
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			if (dist_l0[2*i+1] < dist_l0[2*i]) begin
				dist_l1[i] = dist_l0[2*i+1];
				idx_l1[i]  = idx_l0[2*i+1];
			end else begin
				dist_l1[i] = dist_l0[2*i];
				idx_l1[i]  = idx_l0[2*i];
			end
		end
		for (int i = 0; i < 4; i++) begin
			if (dist_l1[2*i+1] < dist_l1[2*i]) begin
				dist_l2[i] = dist_l1[2*i+1];
				idx_l2[i]  = idx_l1[2*i+1];
			end else begin
				dist_l2[i] = dist_l1[2*i];
				idx_l2[i]  = idx_l1[2*i];
			end
		end
		for (int i = 0; i < 2; i++) begin
			if (dist_l2[2*i+1] < dist_l2[2*i]) begin
				dist_l3[i] = dist_l2[2*i+1];
				idx_l3[i]  = idx_l2[2*i+1];
			end else begin
				dist_l3[i] = dist_l2[2*i];
				idx_l3[i]  = idx_l2[2*i];
			end
		end
		best_idx = (dist_l3[1] < dist_l3[0]) ? idx_l3[1] : idx_l3[0];
	end

	// Output drive
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(npq_pkg::OUT_DATA_W - npq_pkg::IDX_W){1'b0}}, index_s2};

	// Checks
	`NPQ_ASSERT(a_s1_holds_on_stall, (valid_s1 && !adv_s2) |=> (valid_s1 && $stable(pixel_s1)), "input register changed while stalled")
	`NPQ_ASSERT(a_s1_moves_to_s2, (valid_s1 && adv_s2) |=> valid_s2, "item lost between stages")
	`NPQ_ASSERT(a_accept_loads_s1, (s_axis_tvalid && s_axis_tready) |=> valid_s1, "accepted item not held in input register")
	`NPQ_ASSERT_ALWAYS(a_reset_empty, (!arst_n && $past(!arst_n)) |-> (!valid_s1 && !valid_s2), "pipeline not empty in reset")

endmodule

`default_nettype wire
